// ===== rtl/mer_pkg.sv =====
package mer_pkg;

  localparam int AXIS_BITS  = 10;
  localparam int COORD_BITS = 16;
  localparam int CENTER_W   = 15;

  localparam int SQ_W   = 2 * AXIS_BITS;
  localparam int TX_W   = AXIS_BITS + 1;
  localparam int MUL_W  = 2 * TX_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CMP_W  = SQ_W + AXIS_BITS;
  localparam int DEC_W  = 4 * AXIS_BITS + 8;

  localparam int SUM_MIN_W = ((CENTER_W > AXIS_BITS) ? CENTER_W : AXIS_BITS) + 2;
  localparam int EXT_W     = (COORD_BITS > SUM_MIN_W) ? COORD_BITS : SUM_MIN_W;

  localparam int IN_RAW_W   = 2 * CENTER_W + 2 * AXIS_BITS + 1;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 3;

  localparam int UB_POINT = 0;
  localparam int UB_UPPER = 1;
  localparam int UB_FIN   = 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [18:0] {
    ST_IDLE = 19'b0000000000000000001,
    ST_ASQ  = 19'b0000000000000000010,
    ST_BSQ  = 19'b0000000000000000100,
    ST_D0   = 19'b0000000000000001000,
    ST_D1   = 19'b0000000000000010000,
    ST_D2   = 19'b0000000000000100000,
    ST_CL   = 19'b0000000000001000000,
    ST_CR   = 19'b0000000000010000000,
    ST_T1   = 19'b0000000000100000000,
    ST_T2   = 19'b0000000001000000000,
    ST_T3   = 19'b0000000010000000000,
    ST_T4   = 19'b0000000100000000000,
    ST_T5   = 19'b0000001000000000000,
    ST_P1   = 19'b0000010000000000000,
    ST_P2   = 19'b0000100000000000000,
    ST_P3   = 19'b0001000000000000000,
    ST_Q1   = 19'b0010000000000000000,
    ST_Q2   = 19'b0100000000000000000,
    ST_Q3   = 19'b1000000000000000000
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic step_r1;
    logic step_r2;
  } launch_t;

  typedef struct packed {
    logic diag;
    logic less;
  } seq_stat_t;

  typedef struct packed {
    seq_state_t op;
    logic       apply;
    logic       fin_r2;
    logic       busy;
  } seq_ctl_t;

endpackage

// ===== rtl/mer_mul.sv =====
module mer_mul (
  input  logic                       clk,
  input  logic [mer_pkg::MUL_W-1:0]  a,
  input  logic [mer_pkg::MUL_W-1:0]  b,
  output logic [mer_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= mer_pkg::PROD_W'(a) * mer_pkg::PROD_W'(b);
  end

endmodule

// ===== rtl/mer_seq.sv =====
module mer_seq (
  input  logic               clk,
  input  logic               rst,
  input  mer_pkg::launch_t   launch,
  input  mer_pkg::seq_stat_t stat,
  output mer_pkg::seq_ctl_t  ctl
);

  mer_pkg::seq_state_t state;
  mer_pkg::seq_state_t state_next;
  logic                apply;
  logic                fin;

  always_comb begin
    state_next = state;
    fin        = 1'b0;
    case (state)
      mer_pkg::ST_IDLE: begin
        if (launch.start) begin
          state_next = mer_pkg::ST_ASQ;
        end else if (launch.step_r1) begin
          state_next = mer_pkg::ST_P1;
        end else if (launch.step_r2) begin
          state_next = mer_pkg::ST_Q1;
        end
      end
      mer_pkg::ST_ASQ: if (apply) state_next = mer_pkg::ST_BSQ;
      mer_pkg::ST_BSQ: if (apply) state_next = mer_pkg::ST_D0;
      mer_pkg::ST_D0:  if (apply) state_next = mer_pkg::ST_D1;
      mer_pkg::ST_D1:  if (apply) state_next = mer_pkg::ST_D2;
      mer_pkg::ST_D2:  if (apply) state_next = mer_pkg::ST_CL;
      mer_pkg::ST_CL:  if (apply) state_next = mer_pkg::ST_CR;
      mer_pkg::ST_CR: begin
        if (apply) begin
          state_next = stat.less ? mer_pkg::ST_IDLE : mer_pkg::ST_T1;
        end
      end
      mer_pkg::ST_T1:  if (apply) state_next = mer_pkg::ST_T2;
      mer_pkg::ST_T2:  if (apply) state_next = mer_pkg::ST_T3;
      mer_pkg::ST_T3:  if (apply) state_next = mer_pkg::ST_T4;
      mer_pkg::ST_T4:  if (apply) state_next = mer_pkg::ST_T5;
      mer_pkg::ST_T5: begin
        if (apply) begin
          state_next = mer_pkg::ST_IDLE;
          fin        = 1'b1;
        end
      end
      mer_pkg::ST_P1:  if (apply) state_next = mer_pkg::ST_P2;
      mer_pkg::ST_P2: begin
        if (apply) begin
          state_next = stat.diag ? mer_pkg::ST_P3 : mer_pkg::ST_CL;
        end
      end
      mer_pkg::ST_P3:  if (apply) state_next = mer_pkg::ST_CL;
      mer_pkg::ST_Q1:  if (apply) state_next = mer_pkg::ST_Q2;
      mer_pkg::ST_Q2: begin
        if (apply) begin
          if (stat.diag) begin
            state_next = mer_pkg::ST_Q3;
          end else begin
            state_next = mer_pkg::ST_IDLE;
            fin        = 1'b1;
          end
        end
      end
      mer_pkg::ST_Q3: begin
        if (apply) begin
          state_next = mer_pkg::ST_IDLE;
          fin        = 1'b1;
        end
      end
      default: state_next = mer_pkg::ST_IDLE;
    endcase
  end

  // each op multiplies with apply low, then stores or accumulates the registered product with apply high
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mer_pkg::ST_IDLE;
      apply <= 1'b0;
    end else begin
      state <= state_next;
      apply <= (state != mer_pkg::ST_IDLE) && !apply;
    end
  end

  assign ctl.op     = state;
  assign ctl.apply  = apply;
  assign ctl.fin_r2 = fin;
  assign ctl.busy   = (state != mer_pkg::ST_IDLE);

endmodule

// ===== rtl/midpoint_ellipse_raster.sv =====
// Midpoint ellipse rasterizer, two regions, exact integer decision values.
// Input stream (s_axis_*): tuser is the command. A start beat loads centre,
// semi-axes and half mode; a step beat asks for the next point set.
// Output stream (m_axis_*): exactly one result beat per input beat. A step
// result carries centre_x +/- x and centre_y +/- y of the current point;
// flags in tuser mark points, the upper row and a finished curve.
// The result beat is registered from the accepted input beat.
// The input rate is set by the single shared multiplier. Each arithmetic op
// uses it to multiply, then to store the product or accumulate it into the
// decision value. After a start or a region step, the next input beat waits
// for the sequencer; a start or a step that reaches region 2 also computes
// the region 2 decision value, and a step on a finished curve needs no
// sequencer work.
// s_axis_tready is low while the sequencer works and while a result is
// stalled by m_axis_tready low; the held result stays stable until taken.
// Reset (rst, synchronous) returns to idle: no curve, empty output stage,
// and a step then reports finished.
module midpoint_ellipse_raster (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // center_x, center_y, semi_axis_x, semi_axis_y, half_only
  input  logic [mer_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // x_plus, x_minus, y_plus, y_minus
  output logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // point_valid, upper_row_valid, finished
  output logic [mer_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  localparam int A  = mer_pkg::AXIS_BITS;
  localparam int C  = mer_pkg::CENTER_W;
  localparam int E  = mer_pkg::EXT_W;
  localparam int CB = mer_pkg::COORD_BITS;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_R1   = 4'b0010,
    PH_R2   = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t                            phase;
  logic [A-1:0]                      step_x;
  logic [A-1:0]                      step_y;
  logic [A-1:0]                      axis_a;
  logic signed [mer_pkg::DEC_W-1:0]  dec;
  logic signed [mer_pkg::DEC_W-1:0]  dec_next;
  logic [mer_pkg::SQ_W-1:0]          a_sq;
  logic [mer_pkg::SQ_W-1:0]          b_sq;
  logic [mer_pkg::MUL_W-1:0]         tmp;
  logic [mer_pkg::CMP_W-1:0]         cmp_l;
  logic [C-1:0]                      centre_x_held;
  logic [C-1:0]                      centre_y_held;
  logic                              half_held;
  logic                              diag;

  logic                              accept;
  logic                              is_start;
  logic                              active;
  logic                              dec_neg;
  logic                              dec_le0;
  logic [C-1:0]                      in_cx;
  logic [C-1:0]                      in_cy;
  logic [A-1:0]                      in_a;
  logic [A-1:0]                      in_b;
  logic                              in_half;

  logic [mer_pkg::MUL_W-1:0]         mul_a;
  logic [mer_pkg::MUL_W-1:0]         mul_b;
  logic [mer_pkg::PROD_W-1:0]        prod;
  logic signed [mer_pkg::DEC_W-1:0]  prod_ext;
  logic signed [mer_pkg::DEC_W-1:0]  prod_sh2;
  logic signed [mer_pkg::DEC_W-1:0]  prod_sh3;
  logic [mer_pkg::TX_W-1:0]          tx;
  logic [A-1:0]                      tym;

  logic signed [E-1:0]               cx_ext;
  logic signed [E-1:0]               cy_ext;
  logic signed [E-1:0]               x_ext;
  logic signed [E-1:0]               y_ext;
  logic signed [E-1:0]               xp;
  logic signed [E-1:0]               xm;
  logic signed [E-1:0]               yp;
  logic signed [E-1:0]               ym;
  logic [mer_pkg::OUT_DATA_W-1:0]    data_next;
  logic [mer_pkg::OUT_USER_W-1:0]    user_next;

  mer_pkg::launch_t                  launch;
  mer_pkg::seq_stat_t                stat;
  mer_pkg::seq_ctl_t                 ctl;

  assign in_cx   = s_axis_tdata[C-1:0];
  assign in_cy   = s_axis_tdata[2*C-1:C];
  assign in_a    = s_axis_tdata[2*C+A-1:2*C];
  assign in_b    = s_axis_tdata[2*C+2*A-1:2*C+A];
  assign in_half = s_axis_tdata[2*C+2*A];

  assign s_axis_tready = !ctl.busy && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_start      = (s_axis_tuser == mer_pkg::CMD_START);
  assign active        = (phase == PH_R1) || (phase == PH_R2);
  assign dec_neg       = dec[mer_pkg::DEC_W-1];
  assign dec_le0       = dec_neg || (dec == '0);

  assign launch.start   = accept && is_start;
  assign launch.step_r1 = accept && !is_start && (phase == PH_R1);
  assign launch.step_r2 = accept && !is_start && (phase == PH_R2);

  assign stat.diag = diag;
  assign stat.less = cmp_l < prod[mer_pkg::CMP_W-1:0];

  mer_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .stat   (stat),
    .ctl    (ctl)
  );

  assign tx  = {step_x, 1'b1};
  assign tym = (step_y == '0) ? A'(1) : step_y - A'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      mer_pkg::ST_ASQ: begin
        mul_a = mer_pkg::MUL_W'(axis_a);
        mul_b = mer_pkg::MUL_W'(axis_a);
      end
      mer_pkg::ST_BSQ: begin
        mul_a = mer_pkg::MUL_W'(step_y);
        mul_b = mer_pkg::MUL_W'(step_y);
      end
      mer_pkg::ST_D0, mer_pkg::ST_P2: begin
        mul_a = mer_pkg::MUL_W'(b_sq);
        mul_b = mer_pkg::MUL_W'(1);
      end
      mer_pkg::ST_D1, mer_pkg::ST_CR, mer_pkg::ST_P3, mer_pkg::ST_Q2: begin
        mul_a = mer_pkg::MUL_W'(a_sq);
        mul_b = mer_pkg::MUL_W'(step_y);
      end
      mer_pkg::ST_D2, mer_pkg::ST_Q1: begin
        mul_a = mer_pkg::MUL_W'(a_sq);
        mul_b = mer_pkg::MUL_W'(1);
      end
      mer_pkg::ST_CL, mer_pkg::ST_P1, mer_pkg::ST_Q3: begin
        mul_a = mer_pkg::MUL_W'(b_sq);
        mul_b = mer_pkg::MUL_W'(step_x);
      end
      mer_pkg::ST_T1: begin
        mul_a = mer_pkg::MUL_W'(tx);
        mul_b = mer_pkg::MUL_W'(tx);
      end
      mer_pkg::ST_T2: begin
        mul_a = mer_pkg::MUL_W'(b_sq);
        mul_b = tmp;
      end
      mer_pkg::ST_T3: begin
        mul_a = mer_pkg::MUL_W'(tym);
        mul_b = mer_pkg::MUL_W'(tym);
      end
      mer_pkg::ST_T4: begin
        mul_a = mer_pkg::MUL_W'(a_sq);
        mul_b = tmp;
      end
      mer_pkg::ST_T5: begin
        mul_a = mer_pkg::MUL_W'(a_sq);
        mul_b = mer_pkg::MUL_W'(b_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mer_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_ext = signed'(mer_pkg::DEC_W'(prod));
  assign prod_sh2 = prod_ext <<< 2;
  assign prod_sh3 = prod_ext <<< 3;

  always_comb begin
    case (ctl.op)
      mer_pkg::ST_D0: dec_next = prod_sh2;
      mer_pkg::ST_D1: dec_next = dec - prod_sh2;
      mer_pkg::ST_D2: dec_next = dec + prod_ext;
      mer_pkg::ST_T2: dec_next = prod_ext;
      mer_pkg::ST_T4: dec_next = dec + prod_sh2;
      mer_pkg::ST_T5: dec_next = dec - prod_sh2;
      mer_pkg::ST_P1: dec_next = dec + prod_sh3;
      mer_pkg::ST_P2: dec_next = dec + prod_sh2;
      mer_pkg::ST_P3: dec_next = dec - prod_sh3;
      mer_pkg::ST_Q1: dec_next = dec + prod_sh2;
      mer_pkg::ST_Q2: dec_next = dec - prod_sh3;
      mer_pkg::ST_Q3: dec_next = dec + prod_sh3;
      default:        dec_next = dec;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (launch.start) begin
      phase <= PH_R1;
    end else if (ctl.fin_r2) begin
      phase <= (step_y == '0) ? PH_DONE : PH_R2;
    end
  end

  always_ff @(posedge clk) begin
    if (launch.start) begin
      step_x        <= '0;
      step_y        <= in_b;
      axis_a        <= in_a;
      centre_x_held <= in_cx;
      centre_y_held <= in_cy;
      half_held     <= in_half;
    end else if (launch.step_r1) begin
      step_x <= step_x + A'(1);
      if (!dec_neg) begin
        step_y <= step_y - A'(1);
      end
      diag <= !dec_neg;
    end else if (launch.step_r2) begin
      step_y <= step_y - A'(1);
      if (dec_le0) begin
        step_x <= step_x + A'(1);
      end
      diag <= dec_le0;
    end
    if (ctl.apply) begin
      dec <= dec_next;
      case (ctl.op)
        mer_pkg::ST_ASQ:                 a_sq  <= prod[mer_pkg::SQ_W-1:0];
        mer_pkg::ST_BSQ:                 b_sq  <= prod[mer_pkg::SQ_W-1:0];
        mer_pkg::ST_CL:                  cmp_l <= prod[mer_pkg::CMP_W-1:0];
        mer_pkg::ST_T1, mer_pkg::ST_T3:  tmp   <= prod[mer_pkg::MUL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cx_ext = {{(E-C){centre_x_held[C-1]}}, centre_x_held};
  assign cy_ext = {{(E-C){centre_y_held[C-1]}}, centre_y_held};
  assign x_ext  = {{(E-A){1'b0}}, step_x};
  assign y_ext  = {{(E-A){1'b0}}, step_y};
  assign xp     = cx_ext + x_ext;
  assign xm     = cx_ext - x_ext;
  assign yp     = cy_ext + y_ext;
  assign ym     = cy_ext - y_ext;

  always_comb begin
    data_next = '0;
    user_next = '0;
    if (is_start) begin
      user_next[mer_pkg::UB_FIN] = (in_b == '0);
    end else if (active) begin
      data_next[CB-1:0]      = xp[CB-1:0];
      data_next[2*CB-1:CB]   = xm[CB-1:0];
      data_next[3*CB-1:2*CB] = yp[CB-1:0];
      data_next[4*CB-1:3*CB] = ym[CB-1:0];
      user_next[mer_pkg::UB_POINT] = 1'b1;
      user_next[mer_pkg::UB_UPPER] = !half_held;
    end else begin
      user_next[mer_pkg::UB_FIN] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= data_next;
      m_axis_tuser <= user_next;
    end
  end

endmodule

// ===== rtl/mer_chk.sv =====
module mer_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [mer_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat gave no result");

  a_point_not_fin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      !(m_axis_tuser[mer_pkg::UB_POINT] && m_axis_tuser[mer_pkg::UB_FIN]))
    else $error("point beat marked finished");

  a_upper_needs_point: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[mer_pkg::UB_UPPER] |->
      m_axis_tuser[mer_pkg::UB_POINT])
    else $error("upper row flagged without points");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[mer_pkg::UB_POINT] |-> m_axis_tdata == '0)
    else $error("empty beat carries coordinates");

endmodule

bind midpoint_ellipse_raster mer_chk u_mer_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/testbench.sv =====
module testbench;

  typedef struct {
    logic                          cmd;
    logic signed [14:0]            cx;
    logic signed [14:0]            cy;
    logic [mer_pkg::AXIS_BITS-1:0] a;
    logic [mer_pkg::AXIS_BITS-1:0] b;
    logic                          half;
  } ellipse_cmd_t;

  typedef struct {
    logic                           point;
    logic [mer_pkg::COORD_BITS-1:0] x_plus;
    logic [mer_pkg::COORD_BITS-1:0] x_minus;
    logic [mer_pkg::COORD_BITS-1:0] y_plus;
    logic [mer_pkg::COORD_BITS-1:0] y_minus;
    logic                           upper;
    logic                           fin;
  } point_set_t;

  typedef enum {RG_IDLE, RG_ONE, RG_TWO, RG_DONE} walk_region_t;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [mer_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [mer_pkg::OUT_USER_W-1:0] m_axis_tuser;

  walk_region_t region = RG_IDLE;
  int           walk_x = 0;
  int           walk_y = 0;
  longint       decision = 0;
  longint       a_sq = 0;
  longint       b_sq = 0;
  int           cx_held = 0;
  int           cy_held = 0;
  logic         half_held = 1'b0;

  point_set_t pending_sets[$];
  int         error_count = 0;
  int         sent_items = 0;
  int         sender_idle_pct = 0;
  int         reader_stall_pct = 0;

  midpoint_ellipse_raster DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void settle_region();
    longint tx;
    longint ty;
    if (region == RG_ONE && !(b_sq * walk_x < a_sq * walk_y)) begin
      tx = 2 * longint'(walk_x) + 1;
      ty = longint'(walk_y) - 1;
      decision = b_sq * tx * tx + 4 * a_sq * ty * ty - 4 * a_sq * b_sq;
      region = RG_TWO;
    end
    if (region == RG_TWO && walk_y <= 0)
      region = RG_DONE;
  endfunction

  function automatic point_set_t advance_walk(ellipse_cmd_t c);
    point_set_t r;
    r = '{default: '0};
    if (c.cmd == mer_pkg::CMD_START) begin
      cx_held = int'(c.cx);
      cy_held = int'(c.cy);
      half_held = c.half;
      a_sq = longint'(c.a) * longint'(c.a);
      b_sq = longint'(c.b) * longint'(c.b);
      walk_x = 0;
      walk_y = int'(c.b);
      decision = 4 * b_sq - 4 * a_sq * longint'(c.b) + a_sq;
      region = RG_ONE;
      settle_region();
      r.fin = (region == RG_DONE);
      return r;
    end
    if (region != RG_ONE && region != RG_TWO) begin
      r.fin = 1'b1;
      return r;
    end
    r.point = 1'b1;
    r.x_plus = mer_pkg::COORD_BITS'(cx_held + walk_x);
    r.x_minus = mer_pkg::COORD_BITS'(cx_held - walk_x);
    r.y_plus = mer_pkg::COORD_BITS'(cy_held + walk_y);
    r.y_minus = mer_pkg::COORD_BITS'(cy_held - walk_y);
    r.upper = !half_held;
    if (region == RG_ONE) begin
      walk_x++;
      if (decision < 0) begin
        decision += 4 * (2 * b_sq * walk_x + b_sq);
      end else begin
        walk_y--;
        decision += 4 * (2 * b_sq * walk_x - 2 * a_sq * walk_y + b_sq);
      end
    end else begin
      if (decision > 0) begin
        walk_y--;
        decision += 4 * (a_sq - 2 * a_sq * walk_y);
      end else begin
        walk_x++;
        walk_y--;
        decision += 4 * (2 * b_sq * walk_x - 2 * a_sq * walk_y + a_sq);
      end
    end
    settle_region();
    return r;
  endfunction

  function automatic ellipse_cmd_t start_cmd(int cx, int cy, int a, int b, logic half);
    ellipse_cmd_t c;
    c.cmd = mer_pkg::CMD_START;
    c.cx = 15'(cx);
    c.cy = 15'(cy);
    c.a = mer_pkg::AXIS_BITS'(a);
    c.b = mer_pkg::AXIS_BITS'(b);
    c.half = half;
    return c;
  endfunction

  function automatic ellipse_cmd_t random_cmd();
    ellipse_cmd_t c;
    c.cmd = 1'($urandom);
    c.cx = 15'($urandom);
    c.cy = 15'($urandom);
    c.a = mer_pkg::AXIS_BITS'($urandom);
    c.b = mer_pkg::AXIS_BITS'($urandom);
    c.half = 1'($urandom);
    return c;
  endfunction

  task automatic push_command(ellipse_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.cmd;
    s_axis_tdata <= mer_pkg::IN_DATA_W'({c.half, c.b, c.a, c.cy, c.cx});
    do
      @(posedge clk);
    while (!s_axis_tready);
    pending_sets.push_back(advance_walk(c));
    sent_items++;
  endtask

  task automatic push_step();
    ellipse_cmd_t c;
    c = random_cmd();
    c.cmd = mer_pkg::CMD_STEP;
    push_command(c);
  endtask

  // step while the curve has points left, up to a cap, then extra steps past the end if it finished
  task automatic walk_curve(int cap, int extra);
    int n;
    n = 0;
    while ((region == RG_ONE || region == RG_TWO) && n < cap) begin
      push_step();
      n++;
    end
    if (region == RG_DONE)
      repeat (extra) push_step();
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_sets.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(string name, logic [mer_pkg::COORD_BITS-1:0] exp,
                             logic [mer_pkg::COORD_BITS-1:0] act);
    if (exp !== act) begin
      $error("%s expected %0d got %0d", name, $signed(exp), $signed(act));
      error_count++;
    end
  endtask

  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= reader_stall_pct);

  always @(posedge clk) begin
    point_set_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_sets.size() == 0) begin
        $error("result beat with no point set expected");
        error_count++;
      end else begin
        e = pending_sets.pop_front();
        check_field("point_valid", mer_pkg::COORD_BITS'(e.point),
                    mer_pkg::COORD_BITS'(m_axis_tuser[mer_pkg::UB_POINT]));
        check_field("upper_row_valid", mer_pkg::COORD_BITS'(e.upper),
                    mer_pkg::COORD_BITS'(m_axis_tuser[mer_pkg::UB_UPPER]));
        check_field("finished", mer_pkg::COORD_BITS'(e.fin),
                    mer_pkg::COORD_BITS'(m_axis_tuser[mer_pkg::UB_FIN]));
        check_field("x_plus", e.x_plus,
                    m_axis_tdata[0 +: mer_pkg::COORD_BITS]);
        check_field("x_minus", e.x_minus,
                    m_axis_tdata[mer_pkg::COORD_BITS +: mer_pkg::COORD_BITS]);
        check_field("y_plus", e.y_plus,
                    m_axis_tdata[2*mer_pkg::COORD_BITS +: mer_pkg::COORD_BITS]);
        check_field("y_minus", e.y_minus,
                    m_axis_tdata[3*mer_pkg::COORD_BITS +: mer_pkg::COORD_BITS]);
      end
    end
  end

  task automatic test_special_cases();
    sender_idle_pct = 0;
    reader_stall_pct = 0;
    push_step();
    push_command(start_cmd(5, -7, 9, 0, 1'b0));
    push_step();
    push_command(start_cmd(0, 0, 0, 3, 1'b1));
    walk_curve(10, 1);
    push_command(start_cmd(-3, 4, 1, 1, 1'b0));
    walk_curve(10, 0);
    push_command(start_cmd(-16384, 16383, 1023, 1023, 1'b0));
    walk_curve(3, 0);
    push_command(start_cmd(16383, -16384, 1023, 2, 1'b1));
    walk_curve(3, 0);
    push_command(start_cmd(-1, -1, 0, 0, 1'b1));
    push_step();
    hold_until_drained();
  endtask

  task automatic test_random_curves(int n_items, int idle_pct, int stall_pct);
    ellipse_cmd_t c;
    int first;
    int cap;
    bit drained;
    sender_idle_pct = idle_pct;
    reader_stall_pct = stall_pct;
    first = sent_items;
    drained = 0;
    while (sent_items - first < n_items) begin
      if (!drained && sent_items - first > n_items / 2) begin
        hold_until_drained();
        drained = 1;
      end
      if ($urandom_range(99) < 8) begin
        push_command(random_cmd());
      end else begin
        c = random_cmd();
        c.cmd = mer_pkg::CMD_START;
        if ($urandom_range(99) < 10) begin
          cap = $urandom_range(1, 60);
        end else begin
          c.a = mer_pkg::AXIS_BITS'($urandom_range(0, 24));
          c.b = mer_pkg::AXIS_BITS'($urandom_range(0, 24));
          cap = ($urandom_range(99) < 10) ? $urandom_range(0, 10) : 100000;
        end
        push_command(c);
        walk_curve(cap, $urandom_range(0, 2));
      end
    end
    hold_until_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = mer_pkg::CMD_STEP;
    m_axis_tready = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_random_curves(445, 0, 0);
    test_random_curves(445, 79, 0);
    test_random_curves(445, 0, 79);
    test_random_curves(445, 22, 22);
    repeat (30) @(posedge clk);
    if (error_count == 0 && pending_sets.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule
